@@ hw/rtl/madt_pkg.sv @@
`default_nettype none
package madt_pkg;

	localparam int unsigned HEADER_BYTES = 44;

	localparam int unsigned LIMIT_W = 9;
	localparam logic [LIMIT_W-1:0] CPU_LIMIT_RESET = 9'd64;
	localparam logic [LIMIT_W-1:0] IOAPIC_LIMIT_RESET = 9'd8;

	localparam logic REG_CPU_LIMIT = 1'b0;
	localparam logic REG_IOAPIC_LIMIT = 1'b1;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_CPU = 2'd0,
		KIND_IOAPIC = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] apic_id;
		logic [31:0] io_address;
		logic [31:0] irq_base;
		logic [15:0] ordinal;
		logic [15:0] io_count;
		logic within_limit;
		logic last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t word0;
		result_t word1;
	} result_push_t;

endpackage
`default_nettype wire

@@ hw/rtl/madt_entry_parser_unit.sv @@
`default_nettype none
// Walks an interrupt controller description table presented one byte per cycle
// and reports enabled processor entries, I/O controller entries and a final
// done word with both counts. A byte is taken every cycle as long as the
// four-word result queue has room for the results of the byte in the input
// register and of the new byte, two words each; an accepted byte is parsed
// from the input register, and its results are registered into the result
// queue. Results leave at one word per cycle while out_ready is high, so a
// byte that yields an entry and done together gives two words in turn. The
// two limit registers sit at byte addresses 0 and 4 of the APB port.
module madt_entry_parser_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] table_byte,
	input wire logic first_byte,
	input wire logic final_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] apic_id,
	output logic [31:0] io_address,
	output logic [31:0] irq_base,
	output logic [15:0] ordinal,
	output logic [15:0] io_count,
	output logic within_limit,
	output logic last_of_run,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [madt_pkg::LIMIT_W-1:0] cpu_limit;
	logic [madt_pkg::LIMIT_W-1:0] ioapic_limit;
	logic [madt_pkg::QUEUE_CW-1:0] queue_count;
	madt_pkg::result_push_t push;
	madt_pkg::result_t head;

	madt_reg_if u_reg_if (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cpu_limit(cpu_limit),
		.ioapic_limit(ioapic_limit)
	);

	madt_walk u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.table_byte(table_byte),
		.first_byte(first_byte),
		.final_byte(final_byte),
		.cpu_limit(cpu_limit),
		.ioapic_limit(ioapic_limit),
		.queue_count(queue_count),
		.push(push)
	);

	madt_out_queue u_out_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.count(queue_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head(head)
	);

	assign kind = head.kind;
	assign apic_id = head.apic_id;
	assign io_address = head.io_address;
	assign irq_base = head.irq_base;
	assign ordinal = head.ordinal;
	assign io_count = head.io_count;
	assign within_limit = head.within_limit;
	assign last_of_run = head.last_of_run;

endmodule
`default_nettype wire

@@ hw/rtl/madt_reg_if.sv @@
`default_nettype none
module madt_reg_if (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [madt_pkg::LIMIT_W-1:0] cpu_limit,
	output logic [madt_pkg::LIMIT_W-1:0] ioapic_limit
);

	logic [madt_pkg::LIMIT_W-1:0] cpu_limit_q;
	logic [madt_pkg::LIMIT_W-1:0] ioapic_limit_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_limit_q <= madt_pkg::CPU_LIMIT_RESET;
			ioapic_limit_q <= madt_pkg::IOAPIC_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				madt_pkg::REG_CPU_LIMIT: begin
					cpu_limit_q <= pwdata[madt_pkg::LIMIT_W-1:0];
				end
				madt_pkg::REG_IOAPIC_LIMIT: begin
					ioapic_limit_q <= pwdata[madt_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			madt_pkg::REG_CPU_LIMIT: begin
				prdata = {{(32-madt_pkg::LIMIT_W){1'b0}}, cpu_limit_q};
			end
			madt_pkg::REG_IOAPIC_LIMIT: begin
				prdata = {{(32-madt_pkg::LIMIT_W){1'b0}}, ioapic_limit_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign cpu_limit = cpu_limit_q;
	assign ioapic_limit = ioapic_limit_q;

endmodule
`default_nettype wire

@@ hw/rtl/madt_out_queue.sv @@
`default_nettype none
module madt_out_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire madt_pkg::result_push_t push,
	output logic [madt_pkg::QUEUE_CW-1:0] count,
	output logic out_valid,
	input wire logic out_ready,
	output madt_pkg::result_t head
);

	madt_pkg::result_t mem_q [madt_pkg::QUEUE_DEPTH];
	logic [madt_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [madt_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [madt_pkg::QUEUE_CW-1:0] count_q;
	logic pop;
	logic [madt_pkg::QUEUE_AW-1:0] wr_ptr_p1;

	assign pop = out_ready && (count_q != '0);
	assign wr_ptr_p1 = wr_ptr_q + madt_pkg::QUEUE_AW'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.word0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.word1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + madt_pkg::QUEUE_AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + madt_pkg::QUEUE_AW'(1);
			end
			count_q <= count_q + madt_pkg::QUEUE_CW'(push.count)
				- madt_pkg::QUEUE_CW'(pop);
		end
	end

	assign count = count_q;
	assign out_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

@@ hw/rtl/madt_walk.sv @@
`default_nettype none
module madt_walk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] table_byte,
	input wire logic first_byte,
	input wire logic final_byte,
	input wire logic [madt_pkg::LIMIT_W-1:0] cpu_limit,
	input wire logic [madt_pkg::LIMIT_W-1:0] ioapic_limit,
	input wire logic [madt_pkg::QUEUE_CW-1:0] queue_count,
	output madt_pkg::result_push_t push
);

	localparam logic [31:0] HDR = 32'(madt_pkg::HEADER_BYTES);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic first_s1;
	logic final_s1;

	logic [31:0] offset_q;
	logic [31:0] length_q;
	logic [31:0] estart_q;
	logic [7:0] etype_q;
	logic [7:0] elen_q;
	logic [7:0] held_id_q;
	logic [31:0] held_addr_q;
	logic [31:0] held_base_q;
	logic [15:0] cpu_cnt_q;
	logic [15:0] io_cnt_q;
	logic stopped_q;
	logic done_q;

	logic [31:0] offset_n;
	logic [31:0] length_n;
	logic [31:0] estart_n;
	logic [7:0] etype_n;
	logic [7:0] elen_n;
	logic [7:0] held_id_n;
	logic [31:0] held_addr_n;
	logic [31:0] held_base_n;
	logic [15:0] cpu_cnt_n;
	logic [15:0] io_cnt_n;
	logic stopped_n;
	logic done_n;

	logic active;
	logic [31:0] o;
	logic [31:0] r;
	logic in_walk;
	logic ent_hit;
	logic fin_hit;
	madt_pkg::result_t ent_res;
	madt_pkg::result_t done_res;
	logic [madt_pkg::QUEUE_CW:0] need;

	always_comb begin
		need = (madt_pkg::QUEUE_CW+1)'(valid_s1 ? 4 : 2);
		in_ready = ((madt_pkg::QUEUE_CW+1)'(madt_pkg::QUEUE_DEPTH)
			- {1'b0, queue_count}) >= need;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= table_byte;
			first_s1 <= first_byte;
			final_s1 <= final_byte;
		end
	end

	always_comb begin
		active = valid_s1 && (first_s1 || !done_q);
		if (first_s1) begin
			offset_n = '0;
			length_n = '0;
			estart_n = HDR;
			etype_n = '0;
			elen_n = '0;
			held_id_n = '0;
			held_addr_n = '0;
			held_base_n = '0;
			cpu_cnt_n = '0;
			io_cnt_n = '0;
			stopped_n = 1'b0;
			done_n = 1'b0;
		end else begin
			offset_n = offset_q;
			length_n = length_q;
			estart_n = estart_q;
			etype_n = etype_q;
			elen_n = elen_q;
			held_id_n = held_id_q;
			held_addr_n = held_addr_q;
			held_base_n = held_base_q;
			cpu_cnt_n = cpu_cnt_q;
			io_cnt_n = io_cnt_q;
			stopped_n = stopped_q;
			done_n = done_q;
		end

		o = offset_n;
		ent_hit = 1'b0;
		ent_res = '0;
		done_res = '0;

		if (o[31:2] == 30'd1) begin
			length_n[8*o[1:0] +: 8] = byte_s1;
		end

		in_walk = (o >= HDR) && !stopped_n && (o < length_n) && (o >= estart_n);
		r = o - estart_n;

		if (in_walk) begin
			if (r == 32'd0) begin
				etype_n = byte_s1;
			end else if (r == 32'd1) begin
				elen_n = byte_s1;
				if (byte_s1 < 8'd2) begin
					stopped_n = 1'b1;
				end
			end else if (etype_n == 8'd0) begin
				if (r == 32'd3) begin
					held_id_n = byte_s1;
				end else if (r == 32'd4 && byte_s1[0]) begin
					ent_hit = 1'b1;
					ent_res.kind = madt_pkg::KIND_CPU;
					ent_res.apic_id = held_id_n;
					ent_res.ordinal = cpu_cnt_n;
					ent_res.within_limit =
						cpu_cnt_n < {{(16-madt_pkg::LIMIT_W){1'b0}}, cpu_limit};
					cpu_cnt_n = cpu_cnt_n + 16'd1;
				end
			end else if (etype_n == 8'd1) begin
				if (r == 32'd2) begin
					held_id_n = byte_s1;
				end else if (r[31:2] == 30'd1) begin
					held_addr_n[8*r[1:0] +: 8] = byte_s1;
				end else if (r[31:2] == 30'd2) begin
					held_base_n[8*r[1:0] +: 8] = byte_s1;
					if (r[1:0] == 2'd3) begin
						ent_hit = 1'b1;
						ent_res.kind = madt_pkg::KIND_IOAPIC;
						ent_res.apic_id = held_id_n;
						ent_res.io_address = held_addr_n;
						ent_res.irq_base = held_base_n;
						ent_res.ordinal = io_cnt_n;
						ent_res.within_limit =
							io_cnt_n < {{(16-madt_pkg::LIMIT_W){1'b0}}, ioapic_limit};
						io_cnt_n = io_cnt_n + 16'd1;
					end
				end
			end
			if (!stopped_n && r != 32'd0
				&& ({1'b0, r} + 33'd1) == {25'd0, elen_n}) begin
				estart_n = estart_n + {24'd0, elen_n};
			end
		end

		fin_hit = final_s1 || (o >= 32'd7 && ({1'b0, o} + 33'd1) >= {1'b0, length_n});
		done_res.kind = madt_pkg::KIND_DONE;
		done_res.ordinal = cpu_cnt_n;
		done_res.io_count = io_cnt_n;
		done_res.last_of_run = 1'b1;
		if (fin_hit) begin
			done_n = 1'b1;
		end else begin
			ent_res.last_of_run = 1'b1;
		end

		if (o != 32'hFFFF_FFFF) begin
			offset_n = o + 32'd1;
		end

		push.word0 = ent_hit ? ent_res : done_res;
		push.word1 = done_res;
		if (!active) begin
			push.count = 2'd0;
		end else begin
			push.count = {1'b0, ent_hit} + {1'b0, fin_hit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			length_q <= '0;
			estart_q <= HDR;
			etype_q <= '0;
			elen_q <= '0;
			held_id_q <= '0;
			held_addr_q <= '0;
			held_base_q <= '0;
			cpu_cnt_q <= '0;
			io_cnt_q <= '0;
			stopped_q <= 1'b0;
			done_q <= 1'b1;
		end else if (active) begin
			offset_q <= offset_n;
			length_q <= length_n;
			estart_q <= estart_n;
			etype_q <= etype_n;
			elen_q <= elen_n;
			held_id_q <= held_id_n;
			held_addr_q <= held_addr_n;
			held_base_q <= held_base_n;
			cpu_cnt_q <= cpu_cnt_n;
			io_cnt_q <= io_cnt_n;
			stopped_q <= stopped_n;
			done_q <= done_n;
		end
	end

endmodule
`default_nettype wire

@@ verif/madt_entry_parser_unit_tb.sv @@
`timescale 1ns / 1ps

module madt_entry_parser_unit_tb;

	localparam logic [7:0] ENTRY_LOCAL = 8'd0;
	localparam logic [7:0] ENTRY_IO = 8'd1;
	localparam int unsigned PHASE_BYTES = 160;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic [7:0] data;
		logic sof;
		logic eof;
		logic [3:0] gap;
	} byte_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] table_byte = 8'd0;
	logic first_byte = 1'b0;
	logic final_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b1;
	logic [1:0] kind;
	logic [7:0] apic_id;
	logic [31:0] io_address;
	logic [31:0] irq_base;
	logic [15:0] ordinal;
	logic [15:0] io_count;
	logic within_limit;
	logic last_of_run;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;

	madt_entry_parser_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.table_byte(table_byte),
		.first_byte(first_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.apic_id(apic_id),
		.io_address(io_address),
		.irq_base(irq_base),
		.ordinal(ordinal),
		.io_count(io_count),
		.within_limit(within_limit),
		.last_of_run(last_of_run),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	byte_item_t byte_feed[$];
	madt_pkg::result_t words_due[$];
	logic [7:0] tbl[$];
	int unsigned ent_at;
	int unsigned fed_bytes = 0;
	int unsigned bad_words = 0;
	int unsigned quiet_cycles = 0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;

	logic [madt_pkg::LIMIT_W-1:0] lim_cpu = madt_pkg::CPU_LIMIT_RESET;
	logic [madt_pkg::LIMIT_W-1:0] lim_io = madt_pkg::IOAPIC_LIMIT_RESET;
	logic [31:0] w_pos = 32'd0;
	logic [31:0] w_len = 32'd0;
	logic [31:0] w_start = madt_pkg::HEADER_BYTES;
	logic [31:0] w_addr = 32'd0;
	logic [31:0] w_base = 32'd0;
	logic [7:0] w_type = 8'd0;
	logic [7:0] w_elen = 8'd0;
	logic [7:0] w_id = 8'd0;
	logic [15:0] w_cpus = 16'd0;
	logic [15:0] w_ios = 16'd0;
	logic w_stopped = 1'b0;
	logic w_idle = 1'b1;

	function automatic madt_pkg::result_t make_word(input madt_pkg::kind_t k,
			input logic [7:0] id, input logic [31:0] addr, input logic [31:0] base,
			input logic [15:0] ord, input logic [15:0] ioc, input logic in_limit);
		madt_pkg::result_t w;
		w.kind = k;
		w.apic_id = id;
		w.io_address = addr;
		w.irq_base = base;
		w.ordinal = ord;
		w.io_count = ioc;
		w.within_limit = in_limit;
		w.last_of_run = 1'b0;
		return w;
	endfunction

	function automatic void walk_byte(input logic [7:0] b, input logic sof, input logic eof);
		madt_pkg::result_t w[2];
		logic [31:0] o;
		logic [31:0] r;
		int n;
		int k;
		n = 0;
		if (sof) begin
			w_pos = 32'd0;
			w_len = 32'd0;
			w_start = madt_pkg::HEADER_BYTES;
			w_type = 8'd0;
			w_elen = 8'd0;
			w_id = 8'd0;
			w_addr = 32'd0;
			w_base = 32'd0;
			w_cpus = 16'd0;
			w_ios = 16'd0;
			w_stopped = 1'b0;
			w_idle = 1'b0;
		end else if (w_idle) begin
			return;
		end
		o = w_pos;
		if (o >= 4 && o <= 7) begin
			w_len[8 * (o - 4) +: 8] = b;
		end
		if (o >= madt_pkg::HEADER_BYTES && !w_stopped && o < w_len && o >= w_start) begin
			r = o - w_start;
			if (r == 0) begin
				w_type = b;
			end else if (r == 1) begin
				w_elen = b;
				if (b < 2) begin
					w_stopped = 1'b1;
				end
			end else if (w_type == ENTRY_LOCAL) begin
				if (r == 3) begin
					w_id = b;
				end else if (r == 4 && b[0]) begin
					w[n] = make_word(madt_pkg::KIND_CPU, w_id, 32'd0, 32'd0, w_cpus,
						16'd0, w_cpus < lim_cpu);
					n++;
					w_cpus = w_cpus + 16'd1;
				end
			end else if (w_type == ENTRY_IO) begin
				if (r == 2) begin
					w_id = b;
				end else if (r >= 4 && r <= 7) begin
					w_addr[8 * (r - 4) +: 8] = b;
				end else if (r >= 8 && r <= 11) begin
					w_base[8 * (r - 8) +: 8] = b;
					if (r == 11) begin
						w[n] = make_word(madt_pkg::KIND_IOAPIC, w_id, w_addr, w_base,
							w_ios, 16'd0, w_ios < lim_io);
						n++;
						w_ios = w_ios + 16'd1;
					end
				end
			end
			if (!w_stopped && r >= 1 && r + 32'd1 == {24'd0, w_elen}) begin
				w_start = w_start + {24'd0, w_elen};
			end
		end
		if (eof || (o >= 7 && {1'b0, o} + 33'd1 >= {1'b0, w_len})) begin
			w[n] = make_word(madt_pkg::KIND_DONE, 8'd0, 32'd0, 32'd0, w_cpus, w_ios,
				1'b0);
			n++;
			w_idle = 1'b1;
		end
		if (w_pos != 32'hFFFF_FFFF) begin
			w_pos = w_pos + 32'd1;
		end
		for (k = 0; k < n; k++) begin
			w[k].last_of_run = (k == n - 1);
			words_due.push_back(w[k]);
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			bad_words++;
		end
	endfunction

	initial begin
		forever #2 clk = ~clk;
	end

	// Sample both channels at the rising edge, predict accepted bytes and check words.
	always @(posedge clk) begin : monitor
		madt_pkg::result_t due;
		in_fire <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				walk_byte(table_byte, first_byte, final_byte);
			end
			if (out_valid && out_ready) begin
				if (words_due.size() == 0) begin
					$error("word with none due: kind %0d, id 0x%0h", kind, apic_id);
					bad_words++;
				end else begin
					due = words_due.pop_front();
					check_field("kind", due.kind, kind);
					check_field("apic_id", due.apic_id, apic_id);
					check_field("io_address", due.io_address, io_address);
					check_field("irq_base", due.irq_base, irq_base);
					check_field("ordinal", due.ordinal, ordinal);
					check_field("io_count", due.io_count, io_count);
					check_field("within_limit", due.within_limit, within_limit);
					check_field("last_of_run", due.last_of_run, last_of_run);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	always @(negedge clk) begin : driver
		byte_item_t nxt;
		if (arst_n && (!in_valid || in_fire)) begin
			if (byte_feed.size() != 0 && tx_wait >= byte_feed[0].gap) begin
				nxt = byte_feed.pop_front();
				table_byte <= nxt.data;
				first_byte <= nxt.sof;
				final_byte <= nxt.eof;
				in_valid <= 1'b1;
				tx_wait <= 0;
			end else begin
				in_valid <= 1'b0;
				if (byte_feed.size() != 0) begin
					tx_wait <= tx_wait + 1;
				end
			end
		end
	end

	always @(negedge clk) begin : receiver
		int unsigned hold;
		if (out_fire) begin
			if ($urandom_range(0, 31) == 0) begin
				rx_burst = !rx_burst;
			end
			hold = rx_burst ? 0 : $urandom_range(0, 10);
			rx_wait <= hold;
			out_ready <= (hold == 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			out_ready <= (rx_wait == 1);
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic sof, input logic eof);
		byte_item_t item;
		item.data = b;
		item.sof = sof;
		item.eof = eof;
		item.gap = tx_burst ? 4'd0 : 4'($urandom_range(0, 10));
		byte_feed.push_back(item);
	endtask

	task automatic start_header();
		tbl.delete();
		repeat (madt_pkg::HEADER_BYTES) tbl.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic put_entry(input logic [7:0] etype, input logic [7:0] elen);
		int unsigned extra;
		ent_at = tbl.size();
		tbl.push_back(etype);
		tbl.push_back(elen);
		extra = (elen < 2) ? $urandom_range(0, 6) : elen - 2;
		repeat (extra) tbl.push_back(8'($urandom_range(0, 255)));
		if (etype == ENTRY_LOCAL && elen > 4 && $urandom_range(0, 4) != 0) begin
			tbl[ent_at + 4] = tbl[ent_at + 4] | 8'h01;
		end
	endtask

	task automatic set_length(input logic [31:0] decl);
		tbl[4] = decl[7:0];
		tbl[5] = decl[15:8];
		tbl[6] = decl[23:16];
		tbl[7] = decl[31:24];
	endtask

	task automatic emit_table(input logic [31:0] decl, input int unsigned count, input bit eof);
		int unsigned k;
		set_length(decl);
		while (tbl.size() < count) tbl.push_back(8'($urandom_range(0, 255)));
		for (k = 0; k < count; k++) begin
			push_byte(tbl[k], k == 0, eof && k == count - 1);
		end
		fed_bytes += count;
	endtask

	task automatic random_table();
		int unsigned n;
		int unsigned sel;
		int unsigned endpos;
		logic [31:0] decl;
		tx_burst = ($urandom_range(0, 4) == 0);
		start_header();
		n = $urandom_range(0, 8);
		repeat (n) begin
			sel = $urandom_range(0, 19);
			if (sel <= 6) begin
				put_entry(ENTRY_LOCAL, 8'd8);
			end else if (sel <= 10) begin
				put_entry(ENTRY_IO, 8'd12);
			end else if (sel == 11) begin
				put_entry(ENTRY_LOCAL, 8'($urandom_range(5, 20)));
			end else if (sel == 12) begin
				put_entry(ENTRY_IO, 8'($urandom_range(13, 24)));
			end else if (sel <= 14) begin
				put_entry(8'($urandom_range(2, 255)), 8'($urandom_range(2, 20)));
			end else if (sel == 15) begin
				put_entry(ENTRY_LOCAL, 8'($urandom_range(2, 4)));
			end else if (sel == 16) begin
				put_entry(ENTRY_IO, 8'($urandom_range(2, 11)));
			end else if (sel == 17) begin
				put_entry(8'($urandom_range(0, 255)), 8'($urandom_range(0, 1)));
			end else begin
				put_entry(8'($urandom_range(0, 1)), 8'($urandom_range(0, 40)));
			end
		end
		case ($urandom_range(0, 15))
			0: decl = $urandom_range(0, 7);
			1: decl = $urandom_range(8, madt_pkg::HEADER_BYTES);
			2: decl = $urandom_range(madt_pkg::HEADER_BYTES, tbl.size());
			3: decl = 32'hFFFF_FFFF;
			4: decl = $urandom();
			5: decl = tbl.size() + $urandom_range(1, 20);
			default: decl = tbl.size();
		endcase
		endpos = (decl < 8) ? 8 : decl;
		sel = $urandom_range(0, 7);
		if (sel == 0) begin
			emit_table(decl, $urandom_range(1, tbl.size()), 1'b1);
		end else if (sel == 1) begin
			emit_table(decl, $urandom_range(1, tbl.size()), 1'b0);
		end else if (endpos <= tbl.size() + 24) begin
			emit_table(decl, endpos, 1'($urandom_range(0, 1)));
			repeat ($urandom_range(0, 2)) begin
				push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
			end
		end else begin
			emit_table(decl, tbl.size(), 1'b1);
		end
	endtask

	task automatic wait_quiet();
		@(posedge clk);
		while (byte_feed.size() != 0 || in_valid || words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_limits(input logic [madt_pkg::LIMIT_W-1:0] cpu_max,
			input logic [madt_pkg::LIMIT_W-1:0] io_max);
		apb_write(madt_pkg::REG_CPU_LIMIT, {23'd0, cpu_max});
		lim_cpu = cpu_max;
		apb_write(madt_pkg::REG_IOAPIC_LIMIT, {23'd0, io_max});
		lim_io = io_max;
	endtask

	initial begin
		int unsigned k;
		int unsigned ph;
		int unsigned target;

		// Bytes before any table start are dropped, even when marked final.
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);

		start_header();
		put_entry(ENTRY_LOCAL, 8'd8);
		tbl[ent_at + 3] = 8'hFF;
		tbl[ent_at + 4] = 8'h01;
		put_entry(ENTRY_LOCAL, 8'd8);
		tbl[ent_at + 4] = 8'hFE;
		put_entry(ENTRY_IO, 8'd12);
		tbl[ent_at + 2] = 8'h00;
		for (k = 4; k < 12; k++) begin
			tbl[ent_at + k] = (k < 8) ? 8'hFF : 8'h00;
		end
		put_entry(8'h7F, 8'd3);
		put_entry(ENTRY_IO, 8'd6);
		put_entry(ENTRY_LOCAL, 8'd4);
		put_entry(ENTRY_LOCAL, 8'd5);
		tbl[ent_at + 3] = 8'h00;
		tbl[ent_at + 4] = 8'hFF;
		emit_table(tbl.size(), tbl.size(), 1'b0);
		push_byte(8'hFF, 1'b0, 1'b1);
		push_byte(8'h00, 1'b0, 1'b0);

		start_header();
		emit_table(32'd5, 8, 1'b0);

		start_header();
		put_entry(ENTRY_IO, 8'd12);
		emit_table(32'hFFFF_FFFF, tbl.size(), 1'b1);

		start_header();
		put_entry(ENTRY_LOCAL, 8'd8);
		put_entry(ENTRY_IO, 8'd12);
		emit_table(tbl.size() - 3, tbl.size(), 1'b0);

		start_header();
		put_entry(ENTRY_LOCAL, 8'd8);
		put_entry(ENTRY_LOCAL, 8'd1);
		put_entry(ENTRY_LOCAL, 8'd8);
		emit_table(tbl.size(), tbl.size(), 1'b0);

		start_header();
		put_entry(ENTRY_IO, 8'd0);
		put_entry(ENTRY_IO, 8'd12);
		emit_table(tbl.size(), tbl.size(), 1'b0);

		start_header();
		put_entry(ENTRY_LOCAL, 8'd5);
		tbl[ent_at + 4] = 8'h81;
		emit_table(tbl.size(), tbl.size(), 1'b0);

		// A table cut short without a final byte is restarted by the next one.
		start_header();
		put_entry(ENTRY_IO, 8'd12);
		emit_table(tbl.size(), 50, 1'b0);

		start_header();
		emit_table(32'd20, 20, 1'b0);

		start_header();
		emit_table(32'd100, 1, 1'b1);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_quiet();

		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				1: set_limits(9'd0, 9'd0);
				2: set_limits(9'd256, 9'd256);
				3: set_limits(9'd1, 9'd2);
				4: set_limits(9'($urandom_range(0, 8)), 9'($urandom_range(0, 256)));
				default: ;
			endcase
			target = fed_bytes + PHASE_BYTES;
			while (fed_bytes < target) begin
				random_table();
				if ($urandom_range(0, 15) == 0) begin
					wait_quiet();
				end
			end
			wait_quiet();
		end

		if (bad_words == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/madt_pkg.sv
hw/rtl/madt_reg_if.sv
hw/rtl/madt_out_queue.sv
hw/rtl/madt_walk.sv
hw/rtl/madt_entry_parser_unit.sv
verif/madt_entry_parser_unit_tb.sv
